// File: src/prab_pkg.sv
// Shared types, constants and arithmetic helpers for the particle step unit.
// Used by prab_front, prab_queue, prab_back and the top level.
package prab_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [30:0] HALF_WIDTH_RST = 31'(1 << FRAC_BITS);
  localparam logic [30:0] RADIUS_RST     = 31'(5 << FRAC_BITS);
  localparam logic [30:0] TSTEP_RST      = 31'(((1 << FRAC_BITS) + 10) / 20);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Quotient bits of the reflection divider (correction is below 2^33).
  localparam int DIV_STEPS = 33;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    CFG_FUEL_X     = 3'd0,
    CFG_FUEL_Y     = 3'd1,
    CFG_HALF_WIDTH = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_TIME_STEP  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_DEAD    = 2'd0,
    OUT_ABSORB  = 2'd1,
    OUT_FREE    = 2'd2,
    OUT_REFLECT = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [31:0] fuel_x;
    logic signed [31:0] fuel_y;
    logic [30:0]        half_width;
    logic [30:0]        radius;
    logic [30:0]        tstep;
  } cfg_t;

  // Classified particle. Vector fields are final unless need_div is set,
  // in which case they are the originals for the back end to reflect.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    outcome_e           outcome;
    logic               need_div;
    logic               dneg;
    logic [63:0]        dmag;
    logic [63:0]        s;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               still_alive;
    logic               spawn_two;
    outcome_e           outcome;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  // p + floor(prod / 2^FRAC_BITS), unsaturated
  function automatic logic signed [49:0] move_sum(input logic signed [31:0] p,
                                                  input logic signed [63:0] prod);
    logic signed [63:0] st;
    st = prod >>> FRAC_BITS;
    return 50'(p) + 50'(st);
  endfunction

endpackage

// File: src/particle_reflect_absorb_step_unit.sv
// Top level of the particle step unit: configuration registers, front end,
// entry queue and back end. Depends on prab_pkg, prab_front, prab_queue, prab_back.

// One 2-D particle (Q16.16 position and velocity plus alive flag) enters per
// transaction and one updated particle leaves per transaction, in order. Dead,
// absorbed and free-flight particles stream at one per cycle unless the output
// stalls or a reflection holds the back end; a result passes the three front
// stages, the queue and the output register. A reflection away from the origin
// holds the back end through two partial products, a combine step, a 33-step
// bit-serial divider for the radial correction, then saturate, rescale by dt
// and move. A four-entry queue lets the front keep accepting while the back end
// works on a reflection. Configuration (fuel centre, fuel half width, domain
// radius, dt): the user writes it via cfg_we_i/cfg_idx_i/cfg_data_i only while
// the unit is idle (not enforced); indexes past the last register are ignored.
module particle_reflect_absorb_step_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y (32 bits each, low to high)
  input  logic [127:0]  s_axis_tdata,
  // alive
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y (32 bits each, low to high)
  output logic [127:0]  m_axis_tdata,
  // still_alive, spawn_two, outcome[1:0] (low to high)
  output logic [3:0]    m_axis_tuser
);

  prab_pkg::cfg_t     cfg_q;
  logic               push, full, pop, q_valid;
  prab_pkg::entry_t   push_data, q_data;
  prab_pkg::result_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fuel_x     <= '0;
      cfg_q.fuel_y     <= '0;
      cfg_q.half_width <= prab_pkg::HALF_WIDTH_RST;
      cfg_q.radius     <= prab_pkg::RADIUS_RST;
      cfg_q.tstep      <= prab_pkg::TSTEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prab_pkg::CFG_FUEL_X:     cfg_q.fuel_x     <= $signed(cfg_data_i);
        prab_pkg::CFG_FUEL_Y:     cfg_q.fuel_y     <= $signed(cfg_data_i);
        prab_pkg::CFG_HALF_WIDTH: cfg_q.half_width <= cfg_data_i[30:0];
        prab_pkg::CFG_RADIUS:     cfg_q.radius     <= cfg_data_i[30:0];
        prab_pkg::CFG_TIME_STEP:  cfg_q.tstep      <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  prab_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pos_x_i ($signed(s_axis_tdata[31:0])),
    .pos_y_i ($signed(s_axis_tdata[63:32])),
    .vel_x_i ($signed(s_axis_tdata[95:64])),
    .vel_y_i ($signed(s_axis_tdata[127:96])),
    .alive_i (s_axis_tuser),
    .push_o  (push),
    .entry_o (push_data),
    .full_i  (full)
  );

  prab_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  prab_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tstep_i   (cfg_q.tstep),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {res.vy, res.vx, res.py, res.px};
  assign m_axis_tuser = {res.outcome, res.spawn_two, res.still_alive};

endmodule

// File: src/prab_front.sv
// Front end: accepts particles, runs the distance tests and free-flight move
// in three stages and emits classified entries. Depends on prab_pkg.
module prab_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  prab_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   vel_x_i,
  input  logic signed [31:0]   vel_y_i,
  input  logic                 alive_i,
  output logic                 push_o,
  output prab_pkg::entry_t     entry_o,
  input  logic                 full_i
);

  logic en;

  // stage 1
  logic               v1_q;
  logic signed [31:0] px1_q, py1_q, vx1_q, vy1_q;
  logic               alive1_q;
  logic [32:0]        adx1_q, ady1_q;
  logic signed [32:0] dx, dy;

  // stage 2
  logic               v2_q;
  logic signed [31:0] px2_q, py2_q, vx2_q, vy2_q;
  logic               alive2_q, lex2_q, ley2_q;
  logic [61:0]        sqx2_q, sqy2_q, h2_q, r2_q;
  logic signed [63:0] ppx2_q, ppy2_q, a2_q, b2_q, mx2_q, my2_q;

  // stage 3
  logic               v3_q;
  prab_pkg::entry_t   ent3_q, ent_d;

  logic [63:0]        s;
  logic               absorbed, in_domain;
  logic signed [64:0] t;

  assign en      = !v3_q || !full_i;
  assign ready_o = en;
  assign push_o  = v3_q && !full_i;
  assign entry_o = ent3_q;

  assign dx = 33'(pos_x_i) - 33'(cfg_i.fuel_x);
  assign dy = 33'(pos_y_i) - 33'(cfg_i.fuel_y);

  always_comb begin
    s         = $unsigned(ppx2_q) + $unsigned(ppy2_q);
    absorbed  = alive2_q && lex2_q && ley2_q &&
                (63'(sqx2_q) + 63'(sqy2_q) <= 63'(h2_q));
    in_domain = s < 64'(r2_q);
    t         = 65'(a2_q) + 65'(b2_q);

    ent_d          = '0;
    ent_d.px       = px2_q;
    ent_d.py       = py2_q;
    ent_d.vx       = vx2_q;
    ent_d.vy       = vy2_q;
    ent_d.s        = s;
    ent_d.dneg     = t[64];
    ent_d.dmag     = t[64] ? 64'(-t) : 64'(t);
    ent_d.outcome  = prab_pkg::OUT_DEAD;
    if (!alive2_q) begin
      ent_d.outcome = prab_pkg::OUT_DEAD;
    end else if (absorbed) begin
      ent_d.outcome = prab_pkg::OUT_ABSORB;
      ent_d.px      = '0;
      ent_d.py      = '0;
      ent_d.vx      = '0;
      ent_d.vy      = '0;
    end else begin
      ent_d.outcome  = in_domain ? prab_pkg::OUT_FREE : prab_pkg::OUT_REFLECT;
      // reflection at the origin keeps the velocity
      ent_d.need_div = !in_domain && (s != 64'd0);
      if (!ent_d.need_div) begin
        ent_d.px = prab_pkg::sat32(prab_pkg::move_sum(px2_q, mx2_q));
        ent_d.py = prab_pkg::sat32(prab_pkg::move_sum(py2_q, my2_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q    <= pos_x_i;
      py1_q    <= pos_y_i;
      vx1_q    <= vel_x_i;
      vy1_q    <= vel_y_i;
      alive1_q <= alive_i;
      adx1_q   <= dx[32] ? 33'(-dx) : 33'(dx);
      ady1_q   <= dy[32] ? 33'(-dy) : 33'(dy);

      px2_q    <= px1_q;
      py2_q    <= py1_q;
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;
      alive2_q <= alive1_q;
      lex2_q   <= adx1_q <= 33'(cfg_i.half_width);
      ley2_q   <= ady1_q <= 33'(cfg_i.half_width);
      sqx2_q   <= adx1_q[30:0] * adx1_q[30:0];
      sqy2_q   <= ady1_q[30:0] * ady1_q[30:0];
      h2_q     <= cfg_i.half_width * cfg_i.half_width;
      r2_q     <= cfg_i.radius * cfg_i.radius;
      ppx2_q   <= px1_q * px1_q;
      ppy2_q   <= py1_q * py1_q;
      a2_q     <= vx1_q * px1_q;
      b2_q     <= vy1_q * py1_q;
      mx2_q    <= vx1_q * $signed({1'b0, cfg_i.tstep});
      my2_q    <= vy1_q * $signed({1'b0, cfg_i.tstep});

      ent3_q   <= ent_d;
    end
  end

endmodule

// File: src/prab_queue.sv
// Small register FIFO of classified entries between front and back end.
// Depends on prab_pkg.
module prab_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  prab_pkg::entry_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output prab_pkg::entry_t  data_o
);

  prab_pkg::entry_t                 mem_q [prab_pkg::QDEPTH];
  logic [prab_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [prab_pkg::QCNT_W-1:0]      cnt_q;

  assign full_o  = cnt_q == prab_pkg::QCNT_W'(prab_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: src/prab_back.sv
// Back end: retires classified entries into the output register and runs the
// specular reflection (multiply, bit-serial divide, move). Depends on prab_pkg.
module prab_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [30:0]       tstep_i,
  input  logic              q_valid_i,
  input  prab_pkg::entry_t  q_data_i,
  output logic              q_pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output prab_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MLO, S_MHI, S_CMB, S_DIV, S_VEL, S_DT, S_MOVE
  } state_e;

  state_e             st_q;
  logic               ov_q;
  prab_pkg::result_t  res_q, direct, computed;
  logic               slot_free;

  logic signed [31:0] p_q  [2];
  logic signed [31:0] v_q  [2];
  logic [31:0]        pm_q [2];
  logic               pn_q [2];
  logic [63:0]        lo_q [2];
  logic [63:0]        hi_q [2];
  logic [63:0]        r_q  [2];
  logic [32:0]        dl_q [2];
  logic [32:0]        qt_q [2];
  logic signed [31:0] nv_q [2];
  logic signed [63:0] md_q [2];
  logic [63:0]        s_q, dmag_q;
  logic               dneg_q;
  logic [prab_pkg::DCNT_W-1:0] cnt_q;

  logic [95:0]        n   [2];
  logic [64:0]        rr  [2];
  logic               ge  [2];
  logic signed [49:0] vd  [2];

  assign slot_free = !ov_q || ready_i;
  assign q_pop_o   = q_valid_i && (st_q == S_IDLE) && (q_data_i.need_div || slot_free);
  assign valid_o   = ov_q;
  assign res_o     = res_q;

  always_comb begin
    direct.px          = q_data_i.px;
    direct.py          = q_data_i.py;
    direct.vx          = q_data_i.vx;
    direct.vy          = q_data_i.vy;
    direct.outcome     = q_data_i.outcome;
    direct.spawn_two   = q_data_i.outcome == prab_pkg::OUT_ABSORB;
    direct.still_alive = (q_data_i.outcome == prab_pkg::OUT_FREE) ||
                         (q_data_i.outcome == prab_pkg::OUT_REFLECT);

    computed.px          = prab_pkg::sat32(prab_pkg::move_sum(p_q[0], md_q[0]));
    computed.py          = prab_pkg::sat32(prab_pkg::move_sum(p_q[1], md_q[1]));
    computed.vx          = nv_q[0];
    computed.vy          = nv_q[1];
    computed.outcome     = prab_pkg::OUT_REFLECT;
    computed.spawn_two   = 1'b0;
    computed.still_alive = 1'b1;

    for (int i = 0; i < 2; i++) begin
      n[i]  = {hi_q[i], 32'd0} + {32'd0, lo_q[i]};
      rr[i] = {r_q[i], dl_q[i][32]};
      ge[i] = rr[i] >= {1'b0, s_q};
      // v minus signed correction: sign(d)*sign(pa)*quotient
      vd[i] = (dneg_q ^ pn_q[i]) ? 50'(v_q[i]) + 50'(qt_q[i])
                                 : 50'(v_q[i]) - 50'(qt_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ov_q  <= 1'b0;
      res_q <= '0;
    end else begin
      if (q_pop_o && !q_data_i.need_div) begin
        ov_q  <= 1'b1;
        res_q <= direct;
      end else if (st_q == S_MOVE && slot_free) begin
        ov_q  <= 1'b1;
        res_q <= computed;
      end else if (ready_i) begin
        ov_q  <= 1'b0;
      end

      case (st_q)
        S_IDLE: begin
          if (q_pop_o && q_data_i.need_div) st_q <= S_MLO;
        end
        S_MLO:  st_q <= S_MHI;
        S_MHI:  st_q <= S_CMB;
        S_CMB:  st_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == prab_pkg::DCNT_W'(prab_pkg::DIV_STEPS - 1)) st_q <= S_VEL;
        end
        S_VEL:  st_q <= S_DT;
        S_DT:   st_q <= S_MOVE;
        S_MOVE: begin
          if (slot_free) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        p_q[0] <= q_data_i.px;
        p_q[1] <= q_data_i.py;
        v_q[0] <= q_data_i.vx;
        v_q[1] <= q_data_i.vy;
        pm_q[0] <= q_data_i.px[31] ? 32'(-q_data_i.px) : 32'(q_data_i.px);
        pm_q[1] <= q_data_i.py[31] ? 32'(-q_data_i.py) : 32'(q_data_i.py);
        pn_q[0] <= q_data_i.px[31];
        pn_q[1] <= q_data_i.py[31];
        s_q     <= q_data_i.s;
        dmag_q  <= q_data_i.dmag;
        dneg_q  <= q_data_i.dneg;
      end
      S_MLO: begin
        for (int i = 0; i < 2; i++) lo_q[i] <= dmag_q[31:0] * pm_q[i];
      end
      S_MHI: begin
        for (int i = 0; i < 2; i++) hi_q[i] <= dmag_q[63:32] * pm_q[i];
      end
      S_CMB: begin
        // dividend is 2*|d|*|pa|; its top bits already sit below s
        for (int i = 0; i < 2; i++) begin
          r_q[i]  <= n[i][95:32];
          dl_q[i] <= {n[i][31:0], 1'b0};
          qt_q[i] <= '0;
        end
        cnt_q <= '0;
      end
      S_DIV: begin
        for (int i = 0; i < 2; i++) begin
          r_q[i]  <= ge[i] ? 64'(rr[i] - {1'b0, s_q}) : rr[i][63:0];
          dl_q[i] <= {dl_q[i][31:0], 1'b0};
          qt_q[i] <= {qt_q[i][31:0], ge[i]};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      S_VEL: begin
        for (int i = 0; i < 2; i++) nv_q[i] <= prab_pkg::sat32(vd[i]);
      end
      S_DT: begin
        for (int i = 0; i < 2; i++) md_q[i] <= nv_q[i] * $signed({1'b0, tstep_i});
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/sv/tb_particle_reflect_absorb_step_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for particle_reflect_absorb_step_unit: directed and random particles,
// several register settings, bursty source and stalling sink. Depends on prab_pkg and the RTL.
module tb_particle_reflect_absorb_step_unit;

  typedef struct {
    logic [31:0] px, py, vx, vy;
    logic        alive;
  } particle_t;

  typedef struct {
    logic [31:0]        px, py, vx, vy;
    logic               live, spawn;
    prab_pkg::outcome_e outcome;
  } step_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;

  particle_reflect_absorb_step_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  logic signed [63:0] fuel_cx, fuel_cy;
  logic [63:0]        half_w, dom_r, dt;

  particle_t pending_q[$];
  step_t     expected_q[$];
  int        n_err = 0, n_sent = 0, n_got = 0;
  int        n_out[4] = '{0, 0, 0, 0};
  bit        source_on = 1'b0;
  int        burst_left = 0, gap_left = 0;
  int        stall_phase = 0;

  function automatic logic signed [63:0] sat32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return 64'(v);
  endfunction

  // p + floor(v*dt / 2^16), saturated
  function automatic logic signed [63:0] advance(input logic signed [63:0] p,
                                                 input logic signed [63:0] v);
    logic signed [127:0] prod;
    prod = 128'(v) * $signed({64'd0, dt});
    return sat32(128'(p) + (prod >>> 16));
  endfunction

  function automatic step_t predict_step(input particle_t it);
    step_t r;
    logic signed [127:0] px, py, vx, vy, ax, ay, s, d, corr;
    logic [127:0] c;
    px = 128'($signed(it.px)); py = 128'($signed(it.py));
    vx = 128'($signed(it.vx)); vy = 128'($signed(it.vy));
    ax = px - fuel_cx; ay = py - fuel_cy;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    s = px * px + py * py;
    r.live = 1'b0; r.spawn = 1'b0;
    if (!it.alive) begin
      r.outcome = prab_pkg::OUT_DEAD;
    end else if (ax <= half_w && ay <= half_w && ax * ax + ay * ay <= half_w * half_w) begin
      px = 0; py = 0; vx = 0; vy = 0;
      r.spawn = 1'b1; r.outcome = prab_pkg::OUT_ABSORB;
    end else begin
      if (s < dom_r * dom_r) begin
        r.outcome = prab_pkg::OUT_FREE;
      end else begin
        r.outcome = prab_pkg::OUT_REFLECT;
        if (s != 0) begin
          d = vx * px + vy * py;
          // truncate toward zero: magnitude divide, then apply sign
          c = ((d < 0 ? -d : d) * 2 * (px < 0 ? -px : px)) / s;
          corr = ((d < 0) != (px < 0)) ? -$signed(c) : $signed(c);
          c = ((d < 0 ? -d : d) * 2 * (py < 0 ? -py : py)) / s;
          vx = sat32(vx - corr);
          corr = ((d < 0) != (py < 0)) ? -$signed(c) : $signed(c);
          vy = sat32(vy - corr);
        end
      end
      px = advance(64'(px), 64'(vx));
      py = advance(64'(py), 64'(vy));
      r.live = 1'b1;
    end
    r.px = px[31:0]; r.py = py[31:0]; r.vx = vx[31:0]; r.vy = vy[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("mismatch on result %0d: %s got %h expected %h", n_got, what, got, exp);
    n_err++;
  endtask

  task automatic queue_item(input particle_t p);
    pending_q.insert(pending_q.size(), p);
  endtask

  // Driver: bursts of random length, random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.insert(expected_q.size(), predict_step(pending_q.pop_front()));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (source_on && pending_q.size() != 0 && (gap_left == 0 || burst_left > 0)
            && burst_left > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].vy, pending_q[0].vx, pending_q[0].py, pending_q[0].px};
          s_axis_tuser  <= pending_q[0].alive;
          burst_left--;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (burst_left == 0 && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Monitor and sink stall pattern
  always @(posedge clk_i) begin
    step_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_got++;
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction %0d", n_got);
          n_err++;
        end else begin
          e = expected_q.pop_front();
          n_out[e.outcome]++;
          if (m_axis_tdata[31:0] !== e.px) report_mismatch("new_pos_x", m_axis_tdata[31:0], e.px);
          if (m_axis_tdata[63:32] !== e.py)
            report_mismatch("new_pos_y", m_axis_tdata[63:32], e.py);
          if (m_axis_tdata[95:64] !== e.vx)
            report_mismatch("new_vel_x", m_axis_tdata[95:64], e.vx);
          if (m_axis_tdata[127:96] !== e.vy)
            report_mismatch("new_vel_y", m_axis_tdata[127:96], e.vy);
          if (m_axis_tuser[0] !== e.live) report_mismatch("still_alive", m_axis_tuser[0], e.live);
          if (m_axis_tuser[1] !== e.spawn) report_mismatch("spawn_two", m_axis_tuser[1], e.spawn);
          if (m_axis_tuser[3:2] !== e.outcome)
            report_mismatch("outcome", m_axis_tuser[3:2], e.outcome);
        end
      end
      // repeating pattern: free-running, then stall bursts, then random stalls
      stall_phase <= (stall_phase + 1) % 200;
      if (stall_phase < 60) m_axis_tready <= 1'b1;
      else if (stall_phase < 120) m_axis_tready <= (stall_phase % 16) < 10;
      else m_axis_tready <= $urandom_range(0, 2) != 0;
    end
  end

  task automatic write_reg(input prab_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      prab_pkg::CFG_FUEL_X:     fuel_cx = 64'($signed(val));
      prab_pkg::CFG_FUEL_Y:     fuel_cy = 64'($signed(val));
      prab_pkg::CFG_HALF_WIDTH: half_w = {33'd0, val[30:0]};
      prab_pkg::CFG_RADIUS:     dom_r = {33'd0, val[30:0]};
      prab_pkg::CFG_TIME_STEP:  dt = {33'd0, val[30:0]};
      default: begin
      end
    endcase
  endtask

  function automatic logic [31:0] rnd_coord(input int scale);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 * scale)) - scale);
    endcase
  endfunction

  function automatic particle_t rnd_particle(input int scale);
    particle_t p;
    p.px = rnd_coord(scale); p.py = rnd_coord(scale);
    p.vx = rnd_coord(scale); p.vy = rnd_coord(scale);
    p.alive = $urandom_range(0, 7) != 0;
    return p;
  endfunction

  task automatic run_items();
    source_on = 1'b1;
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    source_on = 1'b0;
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    fuel_cx = 0; fuel_cy = 0;
    half_w = 65536; dom_r = 327680; dt = 3277;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: dead pass, absorbed at and on the fuel edge, free flight,
    // reflection, extremes, corner of square outside the fuel circle.
    queue_item('{32'h12345678, 32'h87654321, 32'h7fffffff, 32'h80000000, 1'b0});
    queue_item('{32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 1'b1});
    queue_item('{32'h10000, 32'h0, 32'h5, 32'h5, 1'b1});
    queue_item('{32'h10000, 32'h10000, 32'h10000, 32'h0, 1'b1});
    queue_item('{32'h20000, 32'h20000, 32'h10000, 32'hfffe0000, 1'b1});
    queue_item('{32'h50000, 32'h0, 32'h10000, 32'h10000, 1'b1});
    queue_item('{32'hfffb0000, 32'h0, 32'hfff00000, 32'h0, 1'b1});
    queue_item('{32'h40000, 32'h30000, 32'h7fffffff, 32'h80000000, 1'b1});
    foreach (ext[i]) foreach (ext[j])
      queue_item('{ext[i], ext[j], ext[j], ext[i], 1'b1});
    run_items();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(prab_pkg::CFG_FUEL_X, 32'h00020000);
          write_reg(prab_pkg::CFG_FUEL_Y, 32'hfffe0000);
          write_reg(prab_pkg::CFG_HALF_WIDTH, 32'h00018000);
          write_reg(prab_pkg::CFG_TIME_STEP, 32'h00010000);
        end
        2: begin
          write_reg(prab_pkg::CFG_RADIUS, 32'h0); write_reg(prab_pkg::CFG_HALF_WIDTH, 32'h0);
          write_reg(prab_pkg::CFG_FUEL_X, 32'h0); write_reg(prab_pkg::CFG_FUEL_Y, 32'h0);
        end
        3: begin
          write_reg(prab_pkg::CFG_RADIUS, 32'h7fffffff);
          write_reg(prab_pkg::CFG_TIME_STEP, 32'h7fffffff);
          write_reg(prab_pkg::CFG_FUEL_X, 32'h80000000);
          write_reg(prab_pkg::CFG_FUEL_Y, 32'h7fffffff);
        end
        4: begin
          write_reg(prab_pkg::CFG_HALF_WIDTH, 32'h7fffffff);
          write_reg(prab_pkg::CFG_TIME_STEP, 32'h0);
          write_reg(prab_pkg::CFG_RADIUS, 32'h00030000);
        end
        default: begin
          write_reg(prab_pkg::CFG_FUEL_X, $urandom()); write_reg(prab_pkg::CFG_FUEL_Y, $urandom());
          write_reg(prab_pkg::CFG_HALF_WIDTH, 32'h00008000);
          write_reg(prab_pkg::CFG_RADIUS, 32'h00040000);
          write_reg(prab_pkg::CFG_TIME_STEP, 32'h00000ccd);
        end
      endcase
      repeat (100) queue_item(rnd_particle(ph == 3 ? 32'h7fffffff : 32'h00080000));
      run_items();
    end

    $display("%0d particles in, %0d results out over six register settings", n_sent, n_got);
    $display("dead %0d, absorbed %0d, free %0d, reflected %0d",
             n_out[0], n_out[1], n_out[2], n_out[3]);
    if (n_err == 0) $display("** particle_reflect_absorb_step_unit: PASSED **");
    else $display("** particle_reflect_absorb_step_unit: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("** particle_reflect_absorb_step_unit: FAILED **");
    $finish;
  end
endmodule

// File: filelist.f
src/prab_pkg.sv
src/prab_front.sv
src/prab_queue.sv
src/prab_back.sv
src/particle_reflect_absorb_step_unit.sv
tb/sv/tb_particle_reflect_absorb_step_unit.sv
